// ===== hdl/de_mutant_crossover_element_assert.svh =====
// assertion macros for de_mutant_crossover_element.sv, which checks itself
`ifndef DE_MUTANT_CROSSOVER_ELEMENT_ASSERT_SVH
`define DE_MUTANT_CROSSOVER_ELEMENT_ASSERT_SVH

// condition in this cycle implies consequence in the same cycle
`define DMCE_ASSERT_NOW(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("dmce assertion failed");

// condition in this cycle implies consequence in the next cycle
`define DMCE_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("dmce assertion failed");

`endif

// ===== hdl/dmce_pkg.sv =====
`timescale 1ns / 1ps

package dmce_pkg;

   // mutation schemes, codes outside the list behave as best/1
   typedef enum logic [2:0] {
      OP_BEST1       = 3'd0,
      OP_RAND2       = 3'd1,
      OP_BEST2       = 3'd2,
      OP_CUR_TO_BEST = 3'd3,
      OP_RAND1       = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      CSR_LOWER_BOUND    = 2'd0,
      CSR_UPPER_BOUND    = 2'd1,
      CSR_CROSSOVER_RATE = 2'd2
   } csr_index_type;

   localparam logic signed [31:0] LOWER_BOUND_RESET    = 32'sd0;
   localparam logic signed [31:0] UPPER_BOUND_RESET    = 32'sd65536;
   localparam logic [16:0]        CROSSOVER_RATE_RESET = 17'd58982;

   typedef struct packed {
      logic [2:0]         op;
      logic [15:0]        scale_f;
      logic signed [31:0] best_value;
      logic signed [31:0] current_value;
      logic signed [31:0] pick_one;
      logic signed [31:0] pick_two;
      logic signed [31:0] pick_three;
      logic signed [31:0] pick_four;
      logic signed [31:0] pick_five;
      logic [15:0]        bounce_fraction;
      logic [15:0]        cross_fraction;
      logic               force_mutant;
   } req_type;

   typedef struct packed {
      logic signed [31:0] trial_value;
      logic               took_mutant;
      logic               bounced;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] lower_bound;
      logic signed [31:0] upper_bound;
      logic [16:0]        crossover_rate;
   } cfg_type;

endpackage

// ===== hdl/dmce_datapath.sv =====
`timescale 1ns / 1ps

module dmce_datapath (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  dmce_pkg::req_type req_data,
   input  dmce_pkg::cfg_type cfg,
   output logic              out_valid,
   output dmce_pkg::rsp_type rsp_data
);

   localparam logic signed [51:0] ROUND_HALF = 52'sd32768;
   localparam logic signed [35:0] SAT_MAX    = 36'sh0_7FFF_FFFF;
   localparam logic signed [35:0] SAT_MIN    = -36'sh0_8000_0000;

   function automatic logic signed [32:0] diff33(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      diff33 = $signed({a[31], a}) - $signed({b[31], b});
   endfunction

   // stage 1: operand selection and differences
   logic signed [31:0] base_c;
   logic signed [32:0] da_c, db_c, dl_c, du_c;
   logic               take_c;

   logic               s1_valid_ff;
   logic signed [31:0] s1_base_ff, s1_cur_ff;
   logic signed [32:0] s1_da_ff, s1_db_ff, s1_dl_ff, s1_du_ff;
   logic signed [16:0] s1_f_ff, s1_bf_ff;
   logic               s1_take_ff;

   // stage 2: products
   logic signed [49:0] prod_a_in, prod_b_in, prod_l_in, prod_u_in;
   logic               s2_valid_ff;
   logic signed [31:0] s2_base_ff, s2_cur_ff;
   logic signed [49:0] s2_prod_a_ff, s2_prod_b_ff, s2_prod_l_ff, s2_prod_u_ff;
   logic               s2_take_ff;

   // stage 3: sums and rounding
   logic signed [51:0] acc_m_c, acc_l_c, acc_u_c;
   logic               s3_valid_ff;
   logic signed [35:0] s3_m_ff, s3_vl_ff, s3_vu_ff;
   logic signed [31:0] s3_cur_ff;
   logic               s3_take_ff;

   // stage 4: bound test, crossover, saturation
   logic signed [35:0] lo_ext_c, up_ext_c, v_c;
   logic               bnc_c;
   logic               out_valid_ff;
   dmce_pkg::rsp_type  rsp_ff;

   always_comb begin
      base_c = req_data.best_value;
      da_c   = diff33(req_data.pick_one, req_data.pick_two);
      db_c   = '0;
      case (dmce_pkg::op_type'(req_data.op))
         dmce_pkg::OP_RAND2: begin
            base_c = req_data.pick_one;
            da_c   = diff33(req_data.pick_two, req_data.pick_three);
            db_c   = diff33(req_data.pick_four, req_data.pick_five);
         end
         dmce_pkg::OP_BEST2: begin
            base_c = req_data.best_value;
            da_c   = diff33(req_data.pick_one, req_data.pick_two);
            db_c   = diff33(req_data.pick_three, req_data.pick_four);
         end
         dmce_pkg::OP_CUR_TO_BEST: begin
            base_c = req_data.current_value;
            da_c   = diff33(req_data.best_value, req_data.current_value);
            db_c   = diff33(req_data.pick_one, req_data.pick_two);
         end
         dmce_pkg::OP_RAND1: begin
            base_c = req_data.pick_one;
            da_c   = diff33(req_data.pick_two, req_data.pick_three);
         end
         default: begin
            base_c = req_data.best_value;
            da_c   = diff33(req_data.pick_one, req_data.pick_two);
         end
      endcase
      dl_c   = diff33(req_data.current_value, cfg.lower_bound);
      du_c   = diff33(cfg.upper_bound, req_data.current_value);
      take_c = ({1'b0, req_data.cross_fraction} <= cfg.crossover_rate)
               || req_data.force_mutant;
   end

   always_comb begin
      prod_a_in = s1_f_ff * s1_da_ff;
      prod_b_in = s1_f_ff * s1_db_ff;
      prod_l_in = s1_bf_ff * s1_dl_ff;
      prod_u_in = s1_bf_ff * s1_du_ff;
   end

   always_comb begin
      acc_m_c = $signed({{4{s2_base_ff[31]}}, s2_base_ff, 16'd0})
                + s2_prod_a_ff + s2_prod_b_ff + ROUND_HALF;
      acc_l_c = $signed({{4{cfg.lower_bound[31]}}, cfg.lower_bound, 16'd0})
                + s2_prod_l_ff + ROUND_HALF;
      acc_u_c = $signed({{4{s2_cur_ff[31]}}, s2_cur_ff, 16'd0})
                + s2_prod_u_ff + ROUND_HALF;
   end

   always_comb begin
      lo_ext_c = $signed({{4{cfg.lower_bound[31]}}, cfg.lower_bound});
      up_ext_c = $signed({{4{cfg.upper_bound[31]}}, cfg.upper_bound});
      // lower test first, so inverted bounds bounce everything
      if (s3_m_ff < lo_ext_c) begin
         v_c   = s3_vl_ff;
         bnc_c = 1'b1;
      end else if (s3_m_ff > up_ext_c) begin
         v_c   = s3_vu_ff;
         bnc_c = 1'b1;
      end else begin
         v_c   = s3_m_ff;
         bnc_c = 1'b0;
      end
      if (!s3_take_ff) begin
         v_c = $signed({{4{s3_cur_ff[31]}}, s3_cur_ff});
      end
      if (v_c > SAT_MAX) begin
         v_c = SAT_MAX;
      end else if (v_c < SAT_MIN) begin
         v_c = SAT_MIN;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= in_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      s1_base_ff <= base_c;
      s1_cur_ff  <= req_data.current_value;
      s1_da_ff   <= da_c;
      s1_db_ff   <= db_c;
      s1_dl_ff   <= dl_c;
      s1_du_ff   <= du_c;
      s1_f_ff    <= $signed({1'b0, req_data.scale_f});
      s1_bf_ff   <= $signed({1'b0, req_data.bounce_fraction});
      s1_take_ff <= take_c;

      s2_base_ff   <= s1_base_ff;
      s2_cur_ff    <= s1_cur_ff;
      s2_prod_a_ff <= prod_a_in;
      s2_prod_b_ff <= prod_b_in;
      s2_prod_l_ff <= prod_l_in;
      s2_prod_u_ff <= prod_u_in;
      s2_take_ff   <= s1_take_ff;

      s3_m_ff    <= $signed(acc_m_c[51:16]);
      s3_vl_ff   <= $signed(acc_l_c[51:16]);
      s3_vu_ff   <= $signed(acc_u_c[51:16]);
      s3_cur_ff  <= s2_cur_ff;
      s3_take_ff <= s2_take_ff;

      rsp_ff.trial_value <= $signed(v_c[31:0]);
      rsp_ff.took_mutant <= s3_take_ff;
      rsp_ff.bounced     <= bnc_c;
   end

   assign out_valid = out_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hdl/de_mutant_crossover_element.sv =====
// Differential evolution trial element: mutation, bounce-back and binomial crossover.
//
// Input: an item is taken at a rising edge where start is high and busy is low.
// busy is high only during reset and in the cycle after it; otherwise a new item can be given
// every cycle, so throughput is one item per clock.
// Output: the result sits on rsp_data for one cycle with rsp_valid high, once the
// item has passed the four register stages (operand select and differences,
// products, sums and rounding, bound test and crossover). The receiver cannot
// stall; results leave in order, one per item.
// Registers: csr_index 0 lower bound, 1 upper bound, 2 crossover rate; csr_ready
// is always high. Write them only while no transaction is in flight.
// Reset (synchronous, active high) empties the pipeline and loads the register
// defaults: lower 0.0, upper 1.0, crossover rate 58982.
`timescale 1ns / 1ps

`include "de_mutant_crossover_element_assert.svh"

module de_mutant_crossover_element (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dmce_pkg::req_type req_data,
   output logic              rsp_valid,
   output dmce_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data
);

   logic               busy_ff;
   logic signed [31:0] lower_ff;
   logic signed [31:0] upper_ff;
   logic [16:0]        rate_ff;
   dmce_pkg::cfg_type  cfg;
   logic               accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         lower_ff <= dmce_pkg::LOWER_BOUND_RESET;
         upper_ff <= dmce_pkg::UPPER_BOUND_RESET;
         rate_ff  <= dmce_pkg::CROSSOVER_RATE_RESET;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid) begin
            case (dmce_pkg::csr_index_type'(csr_index))
               dmce_pkg::CSR_LOWER_BOUND:    lower_ff <= $signed(csr_data);
               dmce_pkg::CSR_UPPER_BOUND:    upper_ff <= $signed(csr_data);
               dmce_pkg::CSR_CROSSOVER_RATE: rate_ff  <= csr_data[16:0];
               default: ;
            endcase
         end
      end
   end

   assign busy      = busy_ff;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy_ff;

   always_comb begin
      cfg.lower_bound    = lower_ff;
      cfg.upper_bound    = upper_ff;
      cfg.crossover_rate = rate_ff;
   end

   dmce_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .req_data  (req_data),
      .cfg       (cfg),
      .out_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // every result comes from an accepted transaction
   `DMCE_ASSERT_NOW(a_rsp_from_req, clock, reset, rsp_valid, $past(accept, 4))
   // when crossover keeps the current element it comes through untouched
   `DMCE_ASSERT_NOW(a_keep_current, clock, reset, rsp_valid && !rsp_data.took_mutant, rsp_data.trial_value == $past(req_data.current_value, 4))
   // busy is only ever high while reset sets it, and it clears once reset is released
   `DMCE_ASSERT_NEXT(a_busy_once, clock, reset, 1'b1, !busy)

endmodule
